// ===== rtl/core/sdct_pkg.sv =====
package sdct_pkg;

    localparam int DEF_NUM_ITEMS  = 256;
    localparam int DEF_COUNT_BITS = 16;

    localparam int OPCODE_BITS = 3;
    localparam int ID_BITS     = 8;
    localparam int AMT_BITS    = 16;
    localparam int STATUS_BITS = 2;
    localparam int BID_BITS    = 9;
    localparam int BAMT_BITS   = 17;

    localparam logic [OPCODE_BITS-1:0] OP_ADD_SUP = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_ADD_DEM = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_REM_SUP = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_REM_DEM = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_QUERY   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SHORT  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_SAT    = 2'd3;

endpackage

// ===== rtl/core/sdct_table.sv =====
module sdct_table #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 17
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/sdct_alu.sv =====
module sdct_alu #(
    parameter int OPW = 17
) (
    input  logic           sub,
    input  logic [OPW-1:0] a,
    input  logic [OPW-1:0] b,
    output logic [OPW-1:0] res
);

    logic [OPW-1:0] b_op;

    // Subtraction is a plus the inverted b with a carry in; the top bit flags a below b.
    always_comb
    begin
        b_op = sub ? ~b : b;
        res  = a + b_op + OPW'(sub);
    end

endmodule

// ===== rtl/core/supply_demand_counter_table.sv =====
// Add and remove requests: the table entry is read on acceptance, updated in S_UPD and the
// result registered in S_DONE. Highest-demand query: one table entry read and compared per
// cycle through the shared add/subtract unit and the demand memory read port, then the result
// is registered in S_DONE. No new request is taken until the output registers accept the last result.
// Reset is asynchronous and active low; afterwards a clearing pass writes zero to every entry
// of both tables, and no request is accepted until it completes.
module supply_demand_counter_table #(
    parameter int NUM_ITEMS  = sdct_pkg::DEF_NUM_ITEMS,
    parameter int COUNT_BITS = sdct_pkg::DEF_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sdct_pkg::OPCODE_BITS-1:0]     opcode,
    input  logic [sdct_pkg::ID_BITS-1:0]         item_id,
    input  logic [sdct_pkg::AMT_BITS-1:0]        amount,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sdct_pkg::STATUS_BITS-1:0]     status,
    output logic signed [sdct_pkg::BID_BITS-1:0] best_id,
    output logic signed [sdct_pkg::BAMT_BITS-1:0] best_amount
);

    import sdct_pkg::*;

    localparam int IDX_W = $clog2(NUM_ITEMS);
    localparam int PTR_W = IDX_W + 1;
    localparam int OPW   = ((COUNT_BITS > AMT_BITS) ? COUNT_BITS : AMT_BITS) + 1;
    localparam int ENT_W = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_id_reg, pend_id_next;
    logic                    found_reg, found_next;
    logic [COUNT_BITS-1:0]   top_reg, top_next;
    logic [IDX_W-1:0]        top_id_reg, top_id_next;
    logic [OPCODE_BITS-1:0]  op_reg, op_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [AMT_BITS-1:0]     amt_reg, amt_next;
    logic [STATUS_BITS-1:0]  res_status_reg, res_status_next;
    logic [BID_BITS-1:0]     res_id_reg, res_id_next;
    logic [BAMT_BITS-1:0]    res_amt_reg, res_amt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [BID_BITS-1:0]     best_id_reg, best_id_next;
    logic [BAMT_BITS-1:0]    best_amount_reg, best_amount_next;

    logic                    accept;
    logic                    in_range;
    logic                    is_update;
    logic                    issue;
    logic                    upd_dem;
    logic                    upd_add;
    logic [ENT_W-1:0]        cur_ent;
    logic                    cur_present;
    logic                    alu_sub;
    logic [OPW-1:0]          alu_a;
    logic [OPW-1:0]          alu_b;
    logic [OPW-1:0]          alu_res;
    logic                    sum_sat;
    logic [OPW-1:0]          top_ext;
    logic                    top_clip;
    logic                    do_write;
    logic [ENT_W-1:0]        upd_data;
    logic                    sup_wr_en;
    logic                    dem_wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENT_W-1:0]        wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENT_W-1:0]        sup_rd;
    logic [ENT_W-1:0]        dem_rd;

    sdct_table #(
        .DEPTH  (NUM_ITEMS),
        .DATA_W (ENT_W)
    ) u_supply (
        .clk     (clk),
        .wr_en   (sup_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (sup_rd)
    );

    sdct_table #(
        .DEPTH  (NUM_ITEMS),
        .DATA_W (ENT_W)
    ) u_demand (
        .clk     (clk),
        .wr_en   (dem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (dem_rd)
    );

    sdct_alu #(
        .OPW (OPW)
    ) u_alu (
        .sub (alu_sub),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign best_id     = best_id_reg;
    assign best_amount = best_amount_reg;

    always_comb
    begin
        accept    = in_valid && !in_stall;
        in_range  = int'(item_id) < NUM_ITEMS;
        is_update = (opcode == OP_ADD_SUP) || (opcode == OP_ADD_DEM) ||
                    (opcode == OP_REM_SUP) || (opcode == OP_REM_DEM);
        issue     = (state_reg == S_SCAN) && (ptr_reg != PTR_W'(NUM_ITEMS));

        upd_dem     = (op_reg == OP_ADD_DEM) || (op_reg == OP_REM_DEM);
        upd_add     = (op_reg == OP_ADD_SUP) || (op_reg == OP_ADD_DEM);
        cur_ent     = upd_dem ? dem_rd : sup_rd;
        cur_present = cur_ent[COUNT_BITS];

        if (state_reg == S_SCAN)
        begin
            alu_sub = 1'b1;
            alu_a   = OPW'(top_reg);
            alu_b   = OPW'(dem_rd[COUNT_BITS-1:0]);
        end
        else
        begin
            alu_sub = !upd_add;
            alu_a   = cur_present ? OPW'(cur_ent[COUNT_BITS-1:0]) : '0;
            alu_b   = OPW'(amt_reg);
        end

        sum_sat  = |alu_res[OPW-1:COUNT_BITS];
        top_ext  = OPW'(top_reg);
        top_clip = |top_ext[OPW-1:AMT_BITS];

        rd_en   = (accept && is_update && in_range) || issue;
        rd_addr = (state_reg == S_SCAN) ? ptr_reg[IDX_W-1:0] : IDX_W'(item_id);
    end

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        pend_next        = pend_reg;
        pend_id_next     = pend_id_reg;
        found_next       = found_reg;
        top_next         = top_reg;
        top_id_next      = top_id_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        amt_next         = amt_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_amt_next     = res_amt_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        best_id_next     = best_id_reg;
        best_amount_next = best_amount_reg;
        do_write         = 1'b0;
        upd_data         = '0;
        sup_wr_en        = 1'b0;
        dem_wr_en        = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                sup_wr_en = 1'b1;
                dem_wr_en = 1'b1;
                wr_addr   = ptr_reg[IDX_W-1:0];
                wr_data   = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == PTR_W'(NUM_ITEMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    idx_next        = IDX_W'(item_id);
                    amt_next        = amount;
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_amt_next    = '0;
                    if (is_update)
                    begin
                        if (in_range)
                        begin
                            state_next = S_UPD;
                        end
                        else
                        begin
                            res_status_next = ST_ABSENT;
                            state_next      = S_DONE;
                        end
                    end
                    else if (opcode == OP_QUERY)
                    begin
                        ptr_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        top_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_UPD:
            begin
                if (upd_add)
                begin
                    do_write        = 1'b1;
                    upd_data        = {1'b1, sum_sat ? COUNT_MAX : alu_res[COUNT_BITS-1:0]};
                    res_status_next = sum_sat ? ST_SAT : ST_OK;
                end
                else if (!cur_present)
                begin
                    res_status_next = ST_ABSENT;
                end
                else if (alu_res[OPW-1])
                begin
                    res_status_next = ST_SHORT;
                end
                else
                begin
                    do_write        = 1'b1;
                    upd_data        = {1'b1, alu_res[COUNT_BITS-1:0]};
                    res_status_next = ST_OK;
                end
                sup_wr_en  = do_write && !upd_dem;
                dem_wr_en  = do_write && upd_dem;
                wr_addr    = idx_reg;
                wr_data    = upd_data;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // Entry data is registered and arrives in the cycle after its address; the ids trail the pointer.
                if (pend_reg && dem_rd[COUNT_BITS] && (!found_reg || alu_res[OPW-1]))
                begin
                    found_next  = 1'b1;
                    top_next    = dem_rd[COUNT_BITS-1:0];
                    top_id_next = pend_id_reg;
                end
                pend_next    = issue;
                pend_id_next = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    res_status_next = ST_OK;
                    if (found_reg)
                    begin
                        res_id_next  = BID_BITS'(top_id_reg);
                        res_amt_next = top_clip ? BAMT_BITS'(16'hFFFF)
                                                : BAMT_BITS'(top_ext[AMT_BITS-1:0]);
                    end
                    else
                    begin
                        res_id_next  = '1;
                        res_amt_next = '1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    best_id_next     = res_id_reg;
                    best_amount_next = res_amt_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg     <= pend_id_next;
        top_reg         <= top_next;
        top_id_reg      <= top_id_next;
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        amt_reg         <= amt_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_amt_reg     <= res_amt_next;
        status_reg      <= status_next;
        best_id_reg     <= best_id_next;
        best_amount_reg <= best_amount_next;
    end

endmodule
